>>> sv/slot_table_alloc_and_live_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot table block.
// Every macro checks on the rising edge of clk and is off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_ALLOC_AND_LIVE_SEARCH_ASSERT_SVH
`define SLOT_TABLE_ALLOC_AND_LIVE_SEARCH_ASSERT_SVH

// A condition that must hold at every edge.
`define STA_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define STA_ASSERT_SAME(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define STA_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

>>> sv/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Types and constants shared by the slot table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sta_pkg;

  // Field widths of the command and result beats.
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Command codes; the two unused codes fall to the default arm.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_SET_ALIVE = 3'd2,
    CMD_KILL      = 3'd3,
    CMD_NEXT_UP   = 3'd4,
    CMD_NEXT_DOWN = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_OCCUPIED = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming command beat
    logic commit;  // update the table and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // result register is full and not being taken
  } ctl_stat_t;

endpackage

>>> sv/sta_ctrl.sv
// ----------------------------------------------------------------------------
// sta_ctrl
// Two-state sequencer: take one command beat, then execute it once the
// result register has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sta_ctrl
  import sta_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command outputs.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_stall) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sta_datapath.sv
// ----------------------------------------------------------------------------
// sta_datapath
// Occupied and alive maps, running counts, first-free and circular live
// search encoders, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "slot_table_alloc_and_live_search_assert.svh"

module sta_datapath
  import sta_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            ctl,
  output ctl_stat_t           stat,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SLOT_W-1:0]   in_slot_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_occupied_count,
  output logic [COUNT_W-1:0]  out_alive_count
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  // Wide enough for slot_id, any slot index and SLOT_COUNT itself.
  localparam int EXT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int CNX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Table state and the captured command.
  logic [SLOT_COUNT-1:0] occ_map;
  logic [SLOT_COUNT-1:0] alive_map;
  logic [CNT_W-1:0]      occ_count;
  logic [CNT_W-1:0]      alive_count;
  cmd_t                  cmd_q;
  logic [SLOT_W-1:0]     slot_q;

  // Decoded slot and search windows.
  logic [EXT_W-1:0]      slot_ext;
  logic [EXT_W-1:0]      slot_inc;
  logic [EXT_W-1:0]      up_start;
  logic [EXT_W-1:0]      dn_start;
  logic [IDX_W-1:0]      slot_idx;
  logic                  slot_valid;
  logic                  slot_alive;
  logic [SLOT_COUNT-1:0] live;
  logic [SLOT_COUNT-1:0] up_vec;
  logic [SLOT_COUNT-1:0] dn_vec;

  // Encoder outputs.
  logic                  free_any, up_any, dn_any, live_any;
  logic [IDX_W-1:0]      free_idx, up_idx, live_first, dn_idx, live_last;

  // Table update and result of the current command.
  logic                  wr_en;
  logic                  wr_occ;
  logic                  wr_alive;
  logic [IDX_W-1:0]      wr_idx;
  logic [CNT_W-1:0]      occ_count_next;
  logic [CNT_W-1:0]      alive_count_next;
  logic [EXT_W-1:0]      res_ext;
  status_t               res_status;
  logic [CNX_W-1:0]      occ_wide;
  logic [CNX_W-1:0]      alive_wide;

  // Command capture.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd_t'(in_cmd);
      slot_q <= in_slot_id;
    end
  end

  // Slot decode and start points of the two circular searches.
  always_comb begin
    slot_ext   = EXT_W'(slot_q);
    slot_inc   = slot_ext + EXT_W'(1);
    slot_idx   = slot_ext[IDX_W-1:0];
    slot_valid = (slot_ext < EXT_W'(SLOT_COUNT)) && occ_map[slot_idx];
    slot_alive = slot_valid && alive_map[slot_idx];
    up_start   = (slot_inc >= EXT_W'(SLOT_COUNT)) ? '0 : slot_inc;
    if (slot_ext == '0 || slot_ext >= EXT_W'(SLOT_COUNT)) begin
      dn_start = EXT_W'(SLOT_COUNT - 1);
    end else begin
      dn_start = slot_ext - EXT_W'(1);
    end
  end

  // Live slots at or above the up start, and at or below the down start.
  always_comb begin
    live = occ_map & alive_map;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      up_vec[i] = live[i] && (EXT_W'(i) >= up_start);
      dn_vec[i] = live[i] && (EXT_W'(i) <= dn_start);
    end
  end

  // Lowest-index encoders; the last match in a downward walk wins.
  always_comb begin
    free_any   = 1'b0;
    up_any     = 1'b0;
    live_any   = 1'b0;
    free_idx   = '0;
    up_idx     = '0;
    live_first = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ_map[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (up_vec[i]) begin
        up_any = 1'b1;
        up_idx = IDX_W'(i);
      end
      if (live[i]) begin
        live_any   = 1'b1;
        live_first = IDX_W'(i);
      end
    end
  end

  // Highest-index encoders; the last match in an upward walk wins.
  always_comb begin
    dn_any    = 1'b0;
    dn_idx    = '0;
    live_last = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (dn_vec[i]) begin
        dn_any = 1'b1;
        dn_idx = IDX_W'(i);
      end
      if (live[i]) begin
        live_last = IDX_W'(i);
      end
    end
  end

  // Command execution: table write, count update and result.
  always_comb begin
    wr_en            = 1'b0;
    wr_occ           = 1'b0;
    wr_alive         = 1'b0;
    wr_idx           = slot_idx;
    occ_count_next   = occ_count;
    alive_count_next = alive_count;
    res_ext          = '0;
    res_status       = ST_OK;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (free_any) begin
          wr_en          = 1'b1;
          wr_occ         = 1'b1;
          wr_idx         = free_idx;
          occ_count_next = occ_count + CNT_W'(1);
          res_ext        = EXT_W'(free_idx);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_FREE: begin
        if (slot_valid) begin
          wr_en          = 1'b1;
          occ_count_next = occ_count - CNT_W'(1);
          if (slot_alive) begin
            alive_count_next = alive_count - CNT_W'(1);
          end
        end else begin
          res_status = ST_NOT_OCCUPIED;
        end
      end
      CMD_SET_ALIVE: begin
        if (slot_valid) begin
          wr_en    = 1'b1;
          wr_occ   = 1'b1;
          wr_alive = 1'b1;
          if (!slot_alive) begin
            alive_count_next = alive_count + CNT_W'(1);
          end
        end else begin
          res_status = ST_NOT_OCCUPIED;
        end
      end
      CMD_KILL: begin
        if (slot_valid) begin
          wr_en  = 1'b1;
          wr_occ = 1'b1;
          if (slot_alive) begin
            alive_count_next = alive_count - CNT_W'(1);
          end
        end else begin
          res_status = ST_NOT_OCCUPIED;
        end
      end
      CMD_NEXT_UP: begin
        if (live_any) begin
          res_ext = EXT_W'(up_any ? up_idx : live_first);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_NEXT_DOWN: begin
        if (live_any) begin
          res_ext = EXT_W'(dn_any ? dn_idx : live_last);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    occ_wide   = CNX_W'(occ_count_next);
    alive_wide = CNX_W'(alive_count_next);
  end

  // Table and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_map     <= '0;
      alive_map   <= '0;
      occ_count   <= '0;
      alive_count <= '0;
    end else if (ctl.commit) begin
      if (wr_en) begin
        occ_map[wr_idx]   <= wr_occ;
        alive_map[wr_idx] <= wr_alive;
      end
      occ_count   <= occ_count_next;
      alive_count <= alive_count_next;
    end
  end

  // Result register; a new result may replace one taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_result_slot    <= res_ext[SLOT_W-1:0];
      out_status         <= res_status;
      out_occupied_count <= occ_wide[COUNT_W-1:0];
      out_alive_count    <= alive_wide[COUNT_W-1:0];
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

  // A slot is alive only while it is occupied.
  `STA_ASSERT_ALWAYS(a_alive_in_occ, (alive_map & ~occ_map) == '0, "alive bit on free slot")
  // The alive count never exceeds the occupied count.
  `STA_ASSERT_ALWAYS(a_count_order, alive_count <= occ_count, "alive count above occupied")
  // A result never overwrites one that is still waiting.
  `STA_ASSERT_SAME(a_no_overwrite, ctl.commit, !(out_valid && !out_ready), "result overwritten")
  // A successful allocation raises the occupied count by one.
  `STA_ASSERT_NEXT(a_alloc_count, ctl.commit && cmd_q == CMD_ALLOC && free_any,
    occ_count == $past(occ_count) + CNT_W'(1), "occupied count not advanced")

endmodule

>>> sv/slot_table_alloc_and_live_search.sv
// ----------------------------------------------------------------------------
// slot_table_alloc_and_live_search
// Slot table with first-free allocation and circular search for live slots.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on the s_ group: cmd and slot_id. Each command
// gives exactly one result beat on the m_ group: result_slot, status and the
// occupied and alive counts after the command. Allocate takes the lowest free
// slot; free, set alive and kill act on slot_id; the two searches walk up or
// down circularly from slot_id and may end on slot_id itself.
// An accepted beat is captured in the command register; the command is then
// encoded and executed once the result register has room, which registers the
// table update, the counts and the result. The single-entry sequencer around
// the encoders takes no new beat until the captured command has executed.
// A result waits in an output register; while it is stalled the next command
// is still taken, and it executes once that register is free.
// Reset clears both maps, both counts and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_table_alloc_and_live_search
  import sta_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd[2:0], slot_id[8:3], zero[15:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // result_slot[5:0], status[7:6],
                                 // occupied_count[14:8], alive_count[21:15],
                                 // zero[23:22]
);

  ctl_cmd_t            ctl;
  ctl_stat_t           stat;
  logic [SLOT_W-1:0]   result_slot;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  occupied_count;
  logic [COUNT_W-1:0]  alive_count;

  // Sequencer.
  sta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Table, encoders and result register.
  sta_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .in_cmd             (s_tdata[2:0]),
    .in_slot_id         (s_tdata[8:3]),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_result_slot    (result_slot),
    .out_status         (status),
    .out_occupied_count (occupied_count),
    .out_alive_count    (alive_count)
  );

  // Result beat packing.
  assign m_tdata = {2'b00, alive_count, occupied_count, status, result_slot};

endmodule
